// ===== hdl/arqws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arqws_pkg;

    // sequence-number space
    localparam int SN_BITS    = 12;
    localparam int SPACE      = 1 << SN_BITS;
    localparam int HALF_SPACE = SPACE >> 1;
    localparam int MAX_NACKS  = 63;

    // fixed field widths
    localparam int SN_IN_W    = 12;
    localparam int OUT_W      = 12;
    localparam int WIN_W      = 12;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // window compare width, wide enough for both window reg and half space
    localparam int CMP_W = ((SN_BITS > WIN_W) ? SN_BITS : WIN_W) + 1;

    // gap list storage
    localparam int GAP_AW = (MAX_NACKS > 1) ? $clog2(MAX_NACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_NACKS + 1);

    // front queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration registers
    localparam int              PADDR_W       = 3;
    localparam logic [0:0]      REG_WINDOW    = 1'b0;
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(2048);

    typedef logic [SN_BITS-1:0] sn_t;

    typedef enum logic [1:0] {
        CMD_DELIVER = 2'd0,
        CMD_SKIP    = 2'd1,
        CMD_STATUS  = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVERY = 2'd0,
        KIND_ACK      = 2'd1,
        KIND_NACK     = 2'd2
    } kind_t;

    typedef struct packed {
        cmd_t cmd;
        sn_t  sn;
    } q_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DLV,
        ST_ADV,
        ST_REPORT,
        ST_SCAN,
        ST_ACK,
        ST_NACK_RD,
        ST_NACK_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/arqws_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arqws_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arqws_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arqws_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [arqws_pkg::IN_DATA_W-1:0]   s_tdata,   // sn[11:0], dropped[12]
    input  wire logic                              s_tuser,   // op
    input  wire logic                              clear_busy,
    output logic                                   q_valid,
    output arqws_pkg::q_item_t                     q_item,
    input  wire logic                              q_pop
);

    arqws_pkg::q_item_t                 slot_reg [arqws_pkg::QDEPTH];
    logic [arqws_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [arqws_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [arqws_pkg::QCNT_W-1:0]       count_reg, count_next;
    arqws_pkg::q_item_t                 item_in;
    logic                               push;

    // classify
    always_comb
    begin
        item_in.sn = arqws_pkg::sn_t'(s_tdata[arqws_pkg::SN_IN_W-1:0]);
        priority if (s_tuser)
            item_in.cmd = arqws_pkg::CMD_STATUS;
        else if (s_tdata[arqws_pkg::SN_IN_W])
            item_in.cmd = arqws_pkg::CMD_SKIP;
        else
            item_in.cmd = arqws_pkg::CMD_DELIVER;
    end

    assign s_tready = (count_reg != arqws_pkg::QCNT_W'(arqws_pkg::QDEPTH)) && !clear_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == arqws_pkg::QPTR_W'(arqws_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + arqws_pkg::QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == arqws_pkg::QPTR_W'(arqws_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + arqws_pkg::QPTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + arqws_pkg::QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - arqws_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arqws_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arqws_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [arqws_pkg::WIN_W-1:0]       window,
    input  wire logic                              q_valid,
    input  wire arqws_pkg::q_item_t                q_item,
    output logic                                   q_pop,
    output logic                                   clear_busy,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [arqws_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [arqws_pkg::KIND_W-1:0]           m_tuser,
    output logic                                   m_tlast
);

    localparam int SNW  = arqws_pkg::SN_BITS;
    localparam int OW   = arqws_pkg::OUT_W;
    localparam int CW   = arqws_pkg::CNT_W;
    localparam int GAW  = arqws_pkg::GAP_AW;
    localparam int CMPW = arqws_pkg::CMP_W;

    arqws_pkg::state_t  state_reg, state_next;
    arqws_pkg::sn_t     exp_reg, exp_next;
    arqws_pkg::sn_t     high_reg, high_next;
    arqws_pkg::sn_t     cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      ngaps_reg, ngaps_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               trunc_reg, trunc_next;
    logic               out_valid_reg, out_valid_next;

    arqws_pkg::sn_t     sn_reg, sn_next;
    arqws_pkg::sn_t     hoff_reg, hoff_next;
    arqws_pkg::sn_t     pend_sn_reg, pend_sn_next;
    arqws_pkg::kind_t   out_kind_reg, out_kind_next;
    logic [OW-1:0]      out_rsn_reg, out_rsn_next;
    logic [OW-1:0]      out_exp_reg, out_exp_next;
    logic [OW-1:0]      out_high_reg, out_high_next;
    logic               out_trunc_reg, out_trunc_next;
    logic               out_last_reg, out_last_next;

    // bitmap RAM
    logic               map_we, map_re, map_wdata, map_rdata;
    arqws_pkg::sn_t     map_waddr, map_raddr;

    // gap list RAM
    logic               gap_we, gap_re;
    logic [GAW-1:0]     gap_waddr, gap_raddr;
    arqws_pkg::sn_t     gap_wdata, gap_rdata;

    arqws_ram #(
        .WIDTH (1),
        .DEPTH (arqws_pkg::SPACE)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    arqws_ram #(
        .WIDTH (SNW),
        .DEPTH (arqws_pkg::MAX_NACKS)
    ) u_gaps (
        .clk   (clk),
        .we    (gap_we),
        .waddr (gap_waddr),
        .wdata (gap_wdata),
        .re    (gap_re),
        .raddr (gap_raddr),
        .rdata (gap_rdata)
    );

    assign clear_busy = (state_reg == arqws_pkg::ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tuser    = out_kind_reg;
    assign m_tlast    = out_last_reg;
    assign m_tdata    = {{(arqws_pkg::OUT_DATA_W - 3 * OW - 1){1'b0}},
                         out_trunc_reg, out_high_reg, out_exp_reg, out_rsn_reg};

    always_comb
    begin
        arqws_pkg::sn_t  off;
        arqws_pkg::sn_t  hoff_now;
        arqws_pkg::sn_t  exp_inc;
        logic [CMPW-1:0] win_ext;
        logic [CMPW-1:0] half_ext;
        logic [CMPW-1:0] eff_win;
        logic            in_win;
        logic            out_free;
        logic            stop;
        logic            nack_last;

        off      = sn_reg - exp_reg;
        hoff_now = high_reg - exp_reg;
        exp_inc  = exp_reg + arqws_pkg::sn_t'(1);
        win_ext  = CMPW'(window);
        half_ext = CMPW'(arqws_pkg::HALF_SPACE);
        eff_win  = (win_ext > half_ext) ? half_ext : win_ext;
        in_win   = (CMPW'(off) < eff_win);
        out_free = !out_valid_reg || m_tready;
        stop     = 1'b0;
        nack_last = ((k_reg + CW'(1)) == ngaps_reg);

        state_next     = state_reg;
        exp_next       = exp_reg;
        high_next      = high_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        ngaps_next     = ngaps_reg;
        k_next         = k_reg;
        trunc_next     = trunc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sn_next        = sn_reg;
        hoff_next      = hoff_reg;
        pend_sn_next   = pend_sn_reg;
        out_kind_next  = out_kind_reg;
        out_rsn_next   = out_rsn_reg;
        out_exp_next   = out_exp_reg;
        out_high_next  = out_high_reg;
        out_trunc_next = out_trunc_reg;
        out_last_next  = out_last_reg;

        q_pop     = 1'b0;
        map_we    = 1'b0;
        map_waddr = exp_reg;
        map_wdata = 1'b0;
        map_re    = 1'b0;
        map_raddr = exp_inc;
        gap_we    = 1'b0;
        gap_waddr = ngaps_reg[GAW-1:0];
        gap_wdata = pend_sn_reg;
        gap_re    = 1'b0;
        gap_raddr = k_reg[GAW-1:0];

        unique case (state_reg)
            arqws_pkg::ST_CLEAR:
            begin
                // zero the bitmap, one entry per cycle
                map_we    = 1'b1;
                map_waddr = cnt_reg;
                map_wdata = 1'b0;
                cnt_next  = cnt_reg + arqws_pkg::sn_t'(1);
                if (cnt_reg == arqws_pkg::sn_t'(arqws_pkg::SPACE - 1))
                begin
                    cnt_next   = '0;
                    state_next = arqws_pkg::ST_IDLE;
                end
            end

            arqws_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    sn_next = q_item.sn;
                    unique case (q_item.cmd)
                        arqws_pkg::CMD_DELIVER: state_next = arqws_pkg::ST_DLV;
                        arqws_pkg::CMD_STATUS:
                        begin
                            hoff_next  = hoff_now;
                            cnt_next   = '0;
                            ngaps_next = '0;
                            trunc_next = 1'b0;
                            pend_next  = 1'b0;
                            state_next = arqws_pkg::ST_SCAN;
                        end
                        default:                state_next = arqws_pkg::ST_REPORT;
                    endcase
                end
            end

            arqws_pkg::ST_DLV:
            begin
                state_next = arqws_pkg::ST_REPORT;
                if (in_win)
                begin
                    if (off >= hoff_now)
                    begin
                        high_next = sn_reg + arqws_pkg::sn_t'(1);
                    end
                    if (off == '0)
                    begin
                        // in-order arrival: step past it and start the walk
                        exp_next   = exp_inc;
                        map_re     = 1'b1;
                        map_raddr  = exp_inc;
                        state_next = arqws_pkg::ST_ADV;
                    end
                    else
                    begin
                        map_we    = 1'b1;
                        map_waddr = sn_reg;
                        map_wdata = 1'b1;
                    end
                end
            end

            arqws_pkg::ST_ADV:
            begin
                // rdata holds the bit at exp_reg
                if (map_rdata)
                begin
                    map_we    = 1'b1;
                    map_waddr = exp_reg;
                    map_wdata = 1'b0;
                    exp_next  = exp_inc;
                    map_re    = 1'b1;
                    map_raddr = exp_inc;
                end
                else
                begin
                    state_next = arqws_pkg::ST_REPORT;
                end
            end

            arqws_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = arqws_pkg::KIND_DELIVERY;
                    out_rsn_next   = '0;
                    out_exp_next   = OW'(exp_reg);
                    out_high_next  = OW'(high_reg);
                    out_trunc_next = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = arqws_pkg::ST_IDLE;
                end
            end

            arqws_pkg::ST_SCAN:
            begin
                // one read issued per cycle, result checked the cycle after
                if (pend_reg && !map_rdata)
                begin
                    if (ngaps_reg != CW'(arqws_pkg::MAX_NACKS))
                    begin
                        gap_we     = 1'b1;
                        ngaps_next = ngaps_reg + CW'(1);
                    end
                    else
                    begin
                        trunc_next = 1'b1;
                        stop       = 1'b1;
                    end
                end
                if (stop || (cnt_reg == hoff_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = arqws_pkg::ST_ACK;
                end
                else
                begin
                    map_re       = 1'b1;
                    map_raddr    = exp_reg + cnt_reg;
                    pend_sn_next = exp_reg + cnt_reg;
                    cnt_next     = cnt_reg + arqws_pkg::sn_t'(1);
                    pend_next    = 1'b1;
                end
            end

            arqws_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = arqws_pkg::KIND_ACK;
                    out_rsn_next   = OW'(high_reg);
                    out_exp_next   = OW'(exp_reg);
                    out_high_next  = OW'(high_reg);
                    out_trunc_next = trunc_reg;
                    out_last_next  = (ngaps_reg == '0);
                    k_next         = '0;
                    state_next     = (ngaps_reg == '0) ? arqws_pkg::ST_IDLE
                                                       : arqws_pkg::ST_NACK_RD;
                end
            end

            arqws_pkg::ST_NACK_RD:
            begin
                gap_re     = 1'b1;
                state_next = arqws_pkg::ST_NACK_OUT;
            end

            arqws_pkg::ST_NACK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = arqws_pkg::KIND_NACK;
                    out_rsn_next   = OW'(gap_rdata);
                    out_exp_next   = OW'(exp_reg);
                    out_high_next  = OW'(high_reg);
                    out_trunc_next = trunc_reg;
                    out_last_next  = nack_last;
                    k_next         = k_reg + CW'(1);
                    state_next     = nack_last ? arqws_pkg::ST_IDLE : arqws_pkg::ST_NACK_RD;
                end
            end

            default:
            begin
                state_next = arqws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arqws_pkg::ST_CLEAR;
            exp_reg       <= '0;
            high_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            ngaps_reg     <= '0;
            k_reg         <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            ngaps_reg     <= ngaps_next;
            k_reg         <= k_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sn_reg        <= sn_next;
        hoff_reg      <= hoff_next;
        pend_sn_reg   <= pend_sn_next;
        out_kind_reg  <= out_kind_next;
        out_rsn_reg   <= out_rsn_next;
        out_exp_reg   <= out_exp_next;
        out_high_reg  <= out_high_next;
        out_trunc_reg <= out_trunc_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/arq_receive_window_status.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Delivery word: marks the bitmap or walks the expected pointer past received numbers, then reports;
//   a dropped word is just reported. The bitmap RAM (one read, one write a cycle) sets the walk.
// Status word: an ack, then a nack per gap; the scan reads one bit a cycle.
// Input side takes words into a 2-deep queue while the engine and output register are busy.
// Reset: async, active low; then a bitmap clear during which s_tready stays low.
// window_size resets to 2048.
module arq_receive_window_status (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [arqws_pkg::IN_DATA_W-1:0]     s_tdata,   // sn[11:0], dropped[12], zero pad
    input  wire logic                                s_tuser,   // op: 0 delivery, 1 status request

    // result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [arqws_pkg::OUT_DATA_W-1:0]         m_tdata,   // report_sn[11:0],
                                                                // next_expected[23:12],
                                                                // highest_plus_one[35:24],
                                                                // truncated[36], zero pad
    output logic [arqws_pkg::KIND_W-1:0]             m_tuser,   // kind
    output logic                                     m_tlast,   // last word of the item

    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [arqws_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    logic [arqws_pkg::WIN_W-1:0] window_reg, window_next;
    logic                        clear_busy;
    logic                        q_valid;
    logic                        q_pop;
    arqws_pkg::q_item_t          q_item;
    logic                        reg_sel;

    // register file: one word, window_size at byte 0
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == arqws_pkg::REG_WINDOW);
    assign prdata  = reg_sel ? {{(32 - arqws_pkg::WIN_W){1'b0}}, window_reg} : '0;

    always_comb
    begin
        window_next = window_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            window_next = pwdata[arqws_pkg::WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= arqws_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    // front: accept, classify (deliver / skip / status), queue
    arqws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // back: bitmap update, pointer walk, gap scan and result emission
    arqws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .window     (window_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
